// File: rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_DEQUEUE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		CTRL_IDLE = 1'b0,
		CTRL_EXEC = 1'b1
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
	} spq_cmd_t;

	localparam int unsigned PRIO_BITS   = 3;
	localparam int unsigned STATUS_BITS = 2;
	localparam int unsigned COUNT_BITS  = 5;
	localparam int unsigned OUT_BITS    = 32;

endpackage

// File: rtl/spq_ctrl.sv
// Controller state machine for the sorted priority queue.
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output spq_pkg::spq_cmd_t cmd
);

	spq_pkg::ctrl_state_t state_q, state_d;
	logic                 rsp_valid_q, rsp_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spq_pkg::CTRL_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_stall   = 1'b1;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		rsp_valid_d = rsp_valid_q && rsp_stall;
		unique case (state_q)
			spq_pkg::CTRL_IDLE: begin
				// The result register must be free, or be emptied at this edge.
				req_stall = rsp_valid_q && rsp_stall;
				if (req_valid && !req_stall) begin
					cmd.capture = 1'b1;
					state_d     = spq_pkg::CTRL_EXEC;
				end
			end
			spq_pkg::CTRL_EXEC: begin
				cmd.execute = 1'b1;
				rsp_valid_d = 1'b1;
				state_d     = spq_pkg::CTRL_IDLE;
			end
			default: begin
				state_d = spq_pkg::CTRL_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// File: rtl/spq_datapath.sv
// Slot array, insert and remove logic and result register of the priority queue.
module spq_datapath #(
	parameter int unsigned DEPTH        = 16,
	parameter int unsigned PAYLOAD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  spq_pkg::spq_cmd_t                   cmd,
	input  logic                                opcode,
	input  logic [spq_pkg::PRIO_BITS-1:0]       priority_level,
	input  logic [PAYLOAD_BITS-1:0]             payload,
	output logic [spq_pkg::STATUS_BITS-1:0]     status,
	output logic [spq_pkg::COUNT_BITS-1:0]      entry_count,
	output logic                                out_valid,
	output logic [spq_pkg::PRIO_BITS-1:0]       out_priority,
	output logic [spq_pkg::OUT_BITS-1:0]        out_payload
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	// Operands captured at acceptance.
	spq_pkg::op_t                  op_q;
	logic [spq_pkg::PRIO_BITS-1:0] new_prio_q;
	logic [PAYLOAD_BITS-1:0]       new_data_q;

	// Slot row; slot zero is the head.
	logic [spq_pkg::PRIO_BITS-1:0] slot_prio_q [DEPTH];
	logic [PAYLOAD_BITS-1:0]       slot_data_q [DEPTH];
	logic [CNT_W-1:0]              count_q;

	logic [spq_pkg::PRIO_BITS-1:0] slot_prio_d [DEPTH];
	logic [PAYLOAD_BITS-1:0]       slot_data_d [DEPTH];
	logic [DEPTH-1:0]              keep;
	logic [CNT_W-1:0]              count_d;
	logic                          is_full, is_empty;

	// Result register.
	spq_pkg::status_t              res_status_q, res_status_d;
	logic                          res_valid_q, res_valid_d;
	logic [spq_pkg::PRIO_BITS-1:0] res_prio_q, res_prio_d;
	logic [PAYLOAD_BITS-1:0]       res_data_q, res_data_d;

	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= spq_pkg::op_t'(opcode);
			new_prio_q <= priority_level;
			new_data_q <= payload;
		end
	end

	always_comb begin
		// An occupied slot whose priority is not lower than the new entry stays put.
		for (int i = 0; i < DEPTH; i++) begin
			keep[i] = (CNT_W'(i) < count_q) && (slot_prio_q[i] >= new_prio_q);
		end
		for (int i = 0; i < DEPTH; i++) begin
			slot_prio_d[i] = slot_prio_q[i];
			slot_data_d[i] = slot_data_q[i];
		end
		count_d      = count_q;
		res_status_d = spq_pkg::ST_OK;
		res_valid_d  = 1'b0;
		res_prio_d   = '0;
		res_data_d   = '0;
		unique case (op_q)
			spq_pkg::OP_ENQUEUE: begin
				if (is_full) begin
					res_status_d = spq_pkg::ST_FULL;
				end else begin
					for (int i = 0; i < DEPTH; i++) begin
						if (!keep[i]) begin
							if (i == 0 || keep[(i == 0) ? 0 : i - 1]) begin
								slot_prio_d[i] = new_prio_q;
								slot_data_d[i] = new_data_q;
							end else begin
								slot_prio_d[i] = slot_prio_q[(i == 0) ? 0 : i - 1];
								slot_data_d[i] = slot_data_q[(i == 0) ? 0 : i - 1];
							end
						end
					end
					count_d = count_q + CNT_W'(1);
				end
			end
			spq_pkg::OP_DEQUEUE: begin
				if (is_empty) begin
					res_status_d = spq_pkg::ST_EMPTY;
				end else begin
					res_valid_d = 1'b1;
					res_prio_d  = slot_prio_q[0];
					res_data_d  = slot_data_q[0];
					for (int i = 0; i < DEPTH - 1; i++) begin
						slot_prio_d[i] = slot_prio_q[i + 1];
						slot_data_d[i] = slot_data_q[i + 1];
					end
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
				res_status_d = spq_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			for (int i = 0; i < DEPTH; i++) begin
				slot_prio_q[i] <= slot_prio_d[i];
				slot_data_q[i] <= slot_data_d[i];
			end
			res_prio_q <= res_prio_d;
			res_data_q <= res_data_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			res_status_q <= spq_pkg::ST_OK;
			res_valid_q  <= 1'b0;
		end else if (cmd.execute) begin
			count_q      <= count_d;
			res_status_q <= res_status_d;
			res_valid_q  <= res_valid_d;
		end
	end

	assign status       = res_status_q;
	assign entry_count  = spq_pkg::COUNT_BITS'(count_q);
	assign out_valid    = res_valid_q;
	assign out_priority = res_prio_q;
	assign out_payload  = spq_pkg::OUT_BITS'(res_data_q);

endmodule

// File: rtl/sorted_priority_queue.sv
// A transaction has its operands captured when it is accepted; the controller then executes it
// and registers the result, which the receiver takes from the response channel.
// The controller captures, then executes, and stalls new requests while it executes.
// Insert and remove compare and shift all slots at once, so depth does not change timing.
// Reset clears the entry count and the controller; slot contents are left undefined,
// and slots at or above the count never affect the results.
module sorted_priority_queue #(
	parameter int unsigned DEPTH        = 16,
	parameter int unsigned PAYLOAD_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Request channel.
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic                            opcode,
	input  logic [spq_pkg::PRIO_BITS-1:0]   priority_level,
	input  logic [PAYLOAD_BITS-1:0]         payload,
	// Response channel.
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [spq_pkg::STATUS_BITS-1:0] status,
	output logic [spq_pkg::COUNT_BITS-1:0]  entry_count,
	output logic                            out_valid,
	output logic [spq_pkg::PRIO_BITS-1:0]   out_priority,
	output logic [spq_pkg::OUT_BITS-1:0]    out_payload
);

	// The controller sequences each transaction through capture and execute, and owns
	// the response valid flag. A new request is taken while the previous response is
	// being drained, so the response register never blocks more than it must.
	spq_pkg::spq_cmd_t cmd;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// The datapath holds the sorted slot row. An enqueue lands behind every entry of
	// equal or higher priority, so equal priorities leave in arrival order.
	spq_datapath #(
		.DEPTH        (DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.opcode         (opcode),
		.priority_level (priority_level),
		.payload        (payload),
		.status         (status),
		.entry_count    (entry_count),
		.out_valid      (out_valid),
		.out_priority   (out_priority),
		.out_payload    (out_payload)
	);

endmodule
